// File: rtl/fire_effect_cell_update_assert.svh
// ----------------------------------------------------------------------------
// Fire effect cell update: assertion macros
// Shared concurrent check forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIRE_EFFECT_CELL_UPDATE_ASSERT_SVH
`define FIRE_EFFECT_CELL_UPDATE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define FEC_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("fire effect cell update: check failed");

// A condition that must hold in the cycle after a trigger.
`define FEC_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("fire effect cell update: sequence check failed");

`endif

// File: rtl/fec_pkg.sv
// ----------------------------------------------------------------------------
// Fire effect cell update package
// Sizes, codes, transaction payload types and shared structs of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fec_pkg;

   // Frame geometry and derived widths.
   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;
   localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(STORE_CELLS);
   localparam int POS_W       = ADDR_W + 1;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int STEP_W      = (ROW_W > 1) ? $clog2(ROW_W) : 1;

   // Field and register widths.
   localparam int HEAT_W      = 7;
   localparam int SUM_W       = HEAT_W + 2;
   localparam int CLASS_W     = 2;
   localparam int GLYPH_W     = 4;
   localparam int CFG_WIDTH_W = 8;
   localparam int CFG_HEIGHT_W = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Register reset values.
   localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = CFG_WIDTH_W'(128);
   localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = CFG_HEIGHT_W'(64);
   localparam logic [HEAT_W-1:0]       RESET_SEED   = HEAT_W'(65);

   // Smallest active frame side.
   localparam int MIN_SIDE = 2;

   // Heat thresholds and glyph cap.
   localparam logic [HEAT_W-1:0] HEAT_HOT  = HEAT_W'(15);
   localparam logic [HEAT_W-1:0] HEAT_MID  = HEAT_W'(9);
   localparam logic [HEAT_W-1:0] HEAT_LOW  = HEAT_W'(4);
   localparam logic [GLYPH_W-1:0] GLYPH_MAX = GLYPH_W'(9);

   // Colour class codes.
   localparam logic [CLASS_W-1:0] CLASS_DIM = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_LOW = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_MID = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_HOT = 2'd3;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_SEED_HEAT     = 2'd2
   } csr_index_type;

   // Request operation codes.
   typedef enum logic [0:0] {
      OP_SEED    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   // Kind of work held in the read stage.
   typedef enum logic [1:0] {
      KIND_SEED     = 2'd0,
      KIND_ADVANCE  = 2'd1,
      KIND_PREFETCH = 2'd2
   } kind_type;

   // Request transaction payload.
   typedef struct packed {
      op_type           op;
      logic [COL_W-1:0] seed_column;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [ROW_W-1:0]   cell_row;
      logic [COL_W-1:0]   cell_column;
      logic [HEAT_W-1:0]  heat_value;
      logic [CLASS_W-1:0] colour_class;
      logic [GLYPH_W-1:0] glyph_index;
      logic               visible;
      logic               frame_end;
   } rsp_type;

   // Status of the scan position divider.
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } div_type;

endpackage

`default_nettype wire

// File: rtl/fec_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports sharing an enable, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Reads return the contents before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// File: rtl/fec_posdiv.sv
// ----------------------------------------------------------------------------
// Scan position divider
// Splits the scan position into row and column after each register write,
// one quotient bit per cycle by restoring division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fec_posdiv import fec_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [ADDR_W-1:0]      scan,
   input  wire logic [CFG_WIDTH_W-1:0] width,
   output div_type                     status
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] rem_ff, rem_in;
   logic [ROW_W-1:0]  quo_ff, quo_in;
   logic [POS_W-1:0]  shifted;

   // Divisor shifted to the weight of the current quotient bit.
   assign shifted = POS_W'(width) << step_ff;

   // One restoring step per cycle, from the top quotient bit down.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(ROW_W - 1);
         rem_in  = scan;
         quo_in  = '0;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= shifted) begin
            rem_in          = rem_ff - shifted[ADDR_W-1:0];
            quo_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   // The result is presented for one cycle, while still counted as busy.
   assign status.busy = busy_ff | done_ff;
   assign status.done = done_ff;
   assign status.row  = quo_ff;
   assign status.col  = rem_ff[COL_W-1:0];

endmodule

`default_nettype wire

// File: rtl/fec_shade.sv
// ----------------------------------------------------------------------------
// Heat shader
// Averages the four neighbourhood cells and grades the new heat into a
// colour class and a glyph index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fec_shade import fec_pkg::*; (
   input  wire logic [HEAT_W-1:0] cell_here,
   input  wire logic [HEAT_W-1:0] cell_below,
   input  wire logic [HEAT_W-1:0] cell_right,
   input  wire logic [HEAT_W-1:0] cell_below_right,
   output logic      [HEAT_W-1:0] heat,
   output logic      [CLASS_W-1:0] colour,
   output logic      [GLYPH_W-1:0] glyph
);

   logic [SUM_W-1:0] sum;

   // Truncated average of four cells.
   assign sum  = SUM_W'(cell_here) + SUM_W'(cell_below)
               + SUM_W'(cell_right) + SUM_W'(cell_below_right);
   assign heat = sum[SUM_W-1:2];

   // Colour grading by heat band.
   always_comb begin
      if (heat > HEAT_HOT) begin
         colour = CLASS_HOT;
      end else if (heat > HEAT_MID) begin
         colour = CLASS_MID;
      end else if (heat > HEAT_LOW) begin
         colour = CLASS_LOW;
      end else begin
         colour = CLASS_DIM;
      end
   end

   // The glyph follows the heat up to the last character of the table.
   assign glyph = (heat > HEAT_W'(GLYPH_MAX)) ? GLYPH_MAX : heat[GLYPH_W-1:0];

endmodule

`default_nettype wire

// File: rtl/fire_effect_cell_update.sv
// ----------------------------------------------------------------------------
// Fire effect cell update
// Heat frame buffer with in-place four-cell averaging in scan order.
// ----------------------------------------------------------------------------
// An advance transaction updates the next cell of the scan and returns one
// response; a seed transaction writes the seed heat into a bottom-row cell
// and returns nothing. Both are taken at one per cycle unless responses are
// held back: the heat memory has two read ports, and each advance reads only
// the two cells that enter the neighbourhood while the other two are carried
// over from the previous cell. An advance that does not directly follow the
// advance of the previous cell (first after reset, after the frame wraps,
// after a register write or a scan restart) first prefetches the carried
// pair. After reset a clearing pass zeroes all 8192 memory cells, with no
// request taken. After each register write the request and register ports
// stay busy while the scan position is split into row and column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fire_effect_cell_update import fec_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   `include "fire_effect_cell_update_assert.svh"

   // Configuration registers.
   logic [CFG_WIDTH_W-1:0]  width_ff, width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff, height_in;
   logic [HEAT_W-1:0]       seed_heat_ff, seed_heat_in;
   logic [CFG_WIDTH_W-1:0]  eff_w;
   logic [CFG_HEIGHT_W-1:0] eff_h;
   logic [POS_W-1:0]        row_base_ff, size_ff;

   // Clearing pass.
   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // Scan state.
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic [ROW_W-1:0]  scan_row_ff, scan_row_in;
   logic [COL_W-1:0]  scan_col_ff, scan_col_in;
   logic              chain_ff, chain_in;
   logic              div_start_ff;
   div_type           div_stat;

   // Issue stage.
   logic              csr_fire, busy, issue_ok, restart, is_adv;
   logic              pref_issue, acc, adv_issue, issue, last_issue;
   logic [ADDR_W-1:0] pos;
   logic [ROW_W-1:0]  pos_row;
   logic [COL_W-1:0]  pos_col;
   logic [POS_W-1:0]  addr_a, addr_b;
   logic [CFG_WIDTH_W-1:0] col_max;
   logic [COL_W-1:0]  seed_col;
   logic [ADDR_W-1:0] seed_idx;

   // Read stage.
   logic              s1_valid_ff, s1_valid_in;
   kind_type          s1_kind_ff;
   logic [ADDR_W-1:0] s1_pos_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_last_ff;
   logic [POS_W-1:0]  s1_addr_a_ff, s1_addr_b_ff;
   logic              s1_zero_a_ff, s1_zero_b_ff, s1_fwd_a_ff, s1_fwd_b_ff;
   logic [HEAT_W-1:0] s1_fwd_data_ff;
   logic              s1_fire, s1_free;
   logic [HEAT_W-1:0] rd_a, rd_b, val_a, val_b;

   // Carried neighbourhood pair.
   logic [HEAT_W-1:0] win0_ff, win1_ff;
   logic [POS_W-1:0]  win_addr0_ff, win_addr1_ff;

   // Memory write port.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [HEAT_W-1:0] wr_data;

   // Shader results and response register.
   logic [HEAT_W-1:0]  heat;
   logic [CLASS_W-1:0] colour;
   logic [GLYPH_W-1:0] glyph;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;

   // Register writes.
   assign csr_fire = csr_valid & csr_ready;

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      seed_heat_in = seed_heat_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_in     = csr_data;
            CSR_SCREEN_HEIGHT: height_in    = csr_data[CFG_HEIGHT_W-1:0];
            CSR_SEED_HEAT:     seed_heat_in = csr_data[HEAT_W-1:0];
            default:           width_in     = width_ff;
         endcase
      end
   end

   // Active frame size, saturated into the supported range.
   always_comb begin
      eff_w = width_ff;
      if (width_ff < CFG_WIDTH_W'(MIN_SIDE)) begin
         eff_w = CFG_WIDTH_W'(MIN_SIDE);
      end else if (width_ff > CFG_WIDTH_W'(MAX_COLUMNS)) begin
         eff_w = CFG_WIDTH_W'(MAX_COLUMNS);
      end
      eff_h = height_ff;
      if (height_ff < CFG_HEIGHT_W'(MIN_SIDE)) begin
         eff_h = CFG_HEIGHT_W'(MIN_SIDE);
      end else if (height_ff > CFG_HEIGHT_W'(MAX_ROWS)) begin
         eff_h = CFG_HEIGHT_W'(MAX_ROWS);
      end
   end

   always_ff @(posedge clock) begin
      row_base_ff <= POS_W'(eff_w) * POS_W'(eff_h - 1'b1);
      size_ff     <= row_base_ff + POS_W'(eff_w);
   end

   // Clearing pass through the whole memory after reset.
   assign clear_in      = clear_ff && (clear_addr_ff != ADDR_W'(STORE_CELLS - 1));
   assign clear_addr_in = clear_addr_ff + 1'b1;

   // Issue: a request goes with no clearing, division or held read stage; an advance only when chained.
   assign busy     = div_start_ff | div_stat.busy;
   assign csr_ready = ~busy;
   assign s1_fire  = s1_valid_ff &&
                     ((s1_kind_ff != KIND_ADVANCE) || !rsp_valid_ff || rsp_ready);
   assign s1_free  = ~s1_valid_ff | s1_fire;
   assign issue_ok = ~clear_ff & ~busy & s1_free;
   assign is_adv   = (req_data.op == OP_ADVANCE);
   assign req_ready = issue_ok && (!is_adv || chain_ff);
   assign pref_issue = issue_ok && req_valid && is_adv && !chain_ff;
   assign acc       = req_valid & req_ready;
   assign adv_issue = acc & is_adv;
   assign issue     = acc | pref_issue;

   // Current cell, restarting when the scan lies outside the frame.
   assign restart = ({1'b0, scan_ff} >= size_ff);
   assign pos     = restart ? '0 : scan_ff;
   assign pos_row = restart ? '0 : scan_row_ff;
   assign pos_col = restart ? '0 : scan_col_ff;
   assign last_issue = ({1'b0, pos} == (size_ff - 1'b1));

   // A prefetch reads the pair at the cell, an advance the pair after it.
   assign addr_a = pref_issue ? {1'b0, pos} : ({1'b0, pos} + 1'b1);
   assign addr_b = addr_a + POS_W'(eff_w);

   // Seed target in the bottom row.
   assign col_max  = eff_w - 1'b1;
   assign seed_col = ({1'b0, req_data.seed_column} > col_max) ?
                     col_max[COL_W-1:0] : req_data.seed_column;
   assign seed_idx = row_base_ff[ADDR_W-1:0] + ADDR_W'(seed_col);

   // Scan position bookkeeping.
   always_comb begin
      scan_in     = scan_ff;
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      chain_in    = chain_ff;
      if (csr_fire) begin
         chain_in = 1'b0;
      end
      if (div_stat.done) begin
         scan_row_in = div_stat.row;
         scan_col_in = div_stat.col;
      end
      if (pref_issue) begin
         scan_in     = pos;
         scan_row_in = pos_row;
         scan_col_in = pos_col;
         chain_in    = 1'b1;
      end
      if (adv_issue) begin
         if (last_issue) begin
            scan_in     = '0;
            scan_row_in = '0;
            scan_col_in = '0;
            chain_in    = 1'b0;
         end else begin
            scan_in = pos + 1'b1;
            if ({1'b0, pos_col} == col_max) begin
               scan_col_in = '0;
               scan_row_in = pos_row + 1'b1;
            end else begin
               scan_col_in = pos_col + 1'b1;
            end
         end
      end
   end

   fec_posdiv u_posdiv (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start_ff),
      .scan   (scan_ff),
      .width  (eff_w),
      .status (div_stat)
   );

   // Memory write port: clearing pass, else the read stage as it completes.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s1_pos_ff;
      wr_data = heat;
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else if (s1_fire && (s1_kind_ff == KIND_SEED)) begin
         wr_en   = 1'b1;
         wr_data = seed_heat_ff;
      end else if (s1_fire && (s1_kind_ff == KIND_ADVANCE)) begin
         wr_en   = 1'b1;
      end
   end

   fec_ram #(
      .WIDTH (HEAT_W),
      .DEPTH (STORE_CELLS)
   ) u_heat_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (pref_issue | adv_issue),
      .rd_addr_a (addr_a[ADDR_W-1:0]),
      .rd_addr_b (addr_b[ADDR_W-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Read stage: cells past the frame read zero; a write in the issue cycle
   // is forwarded over the memory's old data.
   assign s1_valid_in = s1_free ? issue : s1_valid_ff;
   assign val_a = s1_zero_a_ff ? '0 : (s1_fwd_a_ff ? s1_fwd_data_ff : rd_a);
   assign val_b = s1_zero_b_ff ? '0 : (s1_fwd_b_ff ? s1_fwd_data_ff : rd_b);

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_kind_ff     <= pref_issue ? KIND_PREFETCH : (is_adv ? KIND_ADVANCE : KIND_SEED);
         s1_pos_ff      <= is_adv ? pos : seed_idx;
         s1_row_ff      <= pos_row;
         s1_col_ff      <= pos_col;
         s1_last_ff     <= last_issue;
         s1_addr_a_ff   <= addr_a;
         s1_addr_b_ff   <= addr_b;
         s1_zero_a_ff   <= (addr_a >= size_ff);
         s1_zero_b_ff   <= (addr_b >= size_ff);
         s1_fwd_a_ff    <= wr_en && ({1'b0, wr_addr} == addr_a);
         s1_fwd_b_ff    <= wr_en && ({1'b0, wr_addr} == addr_b);
         s1_fwd_data_ff <= wr_data;
      end
   end

   fec_shade u_shade (
      .cell_here        (win0_ff),
      .cell_below       (win1_ff),
      .cell_right       (val_a),
      .cell_below_right (val_b),
      .heat             (heat),
      .colour           (colour),
      .glyph            (glyph)
   );

   // Carried pair: refilled from the read stage, patched by seeds.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         if (s1_kind_ff == KIND_SEED) begin
            if (win_addr0_ff == {1'b0, s1_pos_ff}) begin
               win0_ff <= seed_heat_ff;
            end
            if (win_addr1_ff == {1'b0, s1_pos_ff}) begin
               win1_ff <= seed_heat_ff;
            end
         end else begin
            win0_ff      <= val_a;
            win1_ff      <= val_b;
            win_addr0_ff <= s1_addr_a_ff;
            win_addr1_ff <= s1_addr_b_ff;
         end
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && (s1_kind_ff == KIND_ADVANCE)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && (s1_kind_ff == KIND_ADVANCE)) begin
         rsp_ff.cell_row     <= s1_row_ff;
         rsp_ff.cell_column  <= s1_col_ff;
         rsp_ff.heat_value   <= heat;
         rsp_ff.colour_class <= colour;
         rsp_ff.glyph_index  <= glyph;
         rsp_ff.visible      <= ~s1_last_ff;
         rsp_ff.frame_end    <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= RESET_WIDTH;
         height_ff     <= RESET_HEIGHT;
         seed_heat_ff  <= RESET_SEED;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         scan_ff       <= '0;
         scan_row_ff   <= '0;
         scan_col_ff   <= '0;
         chain_ff      <= 1'b0;
         div_start_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         seed_heat_ff  <= seed_heat_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         scan_ff       <= scan_in;
         scan_row_ff   <= scan_row_in;
         scan_col_ff   <= scan_col_in;
         chain_ff      <= chain_in;
         div_start_ff  <= csr_fire;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Checks on the pipeline's own bookkeeping.
   `FEC_ASSERT(a_no_request_while_clearing, !(clear_ff && req_ready))
   `FEC_ASSERT(a_clear_owns_write_port, !(clear_ff && s1_valid_ff))
   `FEC_ASSERT(a_no_response_overwrite, !(s1_fire && (s1_kind_ff == KIND_ADVANCE) && rsp_valid_ff && !rsp_ready))
   `FEC_ASSERT(a_chain_inside_frame, !chain_ff || ({1'b0, scan_ff} < size_ff))
   `FEC_ASSERT_NEXT(a_prefetch_enters_stage, pref_issue, s1_valid_ff && (s1_kind_ff == KIND_PREFETCH))

endmodule

`default_nettype wire

// File: sim/tb_fire_effect_cell_update.sv
// ----------------------------------------------------------------------------
// Fire effect cell update: testbench
// Drives seed and advance transactions through the heat frame block under
// random back-pressure. Each response is checked against a cycle-free model
// of the frame buffer and scan. Register settings are changed between phases,
// with the out-of-range values and the smallest and largest frames among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fire_effect_cell_update;
   import fec_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ITEMS    = 90;
   localparam int CALM_PHASES    = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Model state: the heat frame, the scan and the registers.
   logic [HEAT_W-1:0]       heat_frame [STORE_CELLS];
   int unsigned             scan_pos         = 0;
   logic [CFG_WIDTH_W-1:0]  frame_width_reg  = RESET_WIDTH;
   logic [CFG_HEIGHT_W-1:0] frame_height_reg = RESET_HEIGHT;
   logic [HEAT_W-1:0]       seed_heat_reg    = RESET_SEED;

   rsp_type     expected_cells [$];
   int unsigned error_count     = 0;
   int unsigned stuck_cycles    = 0;
   int unsigned rsp_stall_left  = 0;
   bit          idling_on       = 1'b1;

   fire_effect_cell_update i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Active frame sides, saturated into their legal ranges.
   function automatic int unsigned active_columns();
      int unsigned w = 32'(frame_width_reg);
      if (w < MIN_SIDE) w = MIN_SIDE;
      if (w > MAX_COLUMNS) w = MAX_COLUMNS;
      return w;
   endfunction

   function automatic int unsigned active_rows();
      int unsigned h = 32'(frame_height_reg);
      if (h < MIN_SIDE) h = MIN_SIDE;
      if (h > MAX_ROWS) h = MAX_ROWS;
      return h;
   endfunction

   // Cells at or beyond the end of the frame read as cold.
   function automatic int unsigned frame_cell(int unsigned idx, int unsigned size);
      if (idx >= size) return 0;
      return 32'(heat_frame[ADDR_W'(idx)]);
   endfunction

   function automatic void apply_register_write(logic [CSR_INDEX_W-1:0] index,
                                                logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_SCREEN_WIDTH:  frame_width_reg = data;
         CSR_SCREEN_HEIGHT: frame_height_reg = data[CFG_HEIGHT_W-1:0];
         CSR_SEED_HEAT:     seed_heat_reg = data[HEAT_W-1:0];
         default: ;
      endcase
   endfunction

   // Applies one request to the model frame and queues the cell it reports.
   function automatic void predict_cell_update(req_type item);
      int unsigned w, h, size, col, pos, sum, heat;
      rsp_type     model_rsp;
      w    = active_columns();
      h    = active_rows();
      size = w * h;
      if (item.op == OP_SEED) begin
         col = 32'(item.seed_column);
         if (col > w - 1) col = w - 1;
         heat_frame[ADDR_W'(w * (h - 1) + col)] = seed_heat_reg;
      end else begin
         pos = scan_pos;
         if (pos >= size) pos = 0;
         sum = frame_cell(pos, size) + frame_cell(pos + 1, size)
             + frame_cell(pos + w, size) + frame_cell(pos + w + 1, size);
         heat = sum / 4;
         heat_frame[ADDR_W'(pos)] = HEAT_W'(heat);
         model_rsp.cell_row    = ROW_W'(pos / w);
         model_rsp.cell_column = COL_W'(pos % w);
         model_rsp.heat_value  = HEAT_W'(heat);
         if (heat > HEAT_HOT) model_rsp.colour_class = CLASS_HOT;
         else if (heat > HEAT_MID) model_rsp.colour_class = CLASS_MID;
         else if (heat > HEAT_LOW) model_rsp.colour_class = CLASS_LOW;
         else model_rsp.colour_class = CLASS_DIM;
         model_rsp.glyph_index = (heat > HEAT_MID) ? GLYPH_MAX : GLYPH_W'(heat);
         model_rsp.visible     = (pos != size - 1);
         model_rsp.frame_end   = (pos == size - 1);
         expected_cells.push_back(model_rsp);
         scan_pos = (pos == size - 1) ? 0 : pos + 1;
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Every transaction is taken into the model at the edge that accepts it.
   always @(posedge clock) begin : track_block
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_register_write(csr_index, csr_data);
         if (req_valid && req_ready) predict_cell_update(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_cells.pop_front();
               check_field("cell_row", 32'(want.cell_row), 32'(rsp_data.cell_row));
               check_field("cell_column", 32'(want.cell_column),
                           32'(rsp_data.cell_column));
               check_field("heat_value", 32'(want.heat_value), 32'(rsp_data.heat_value));
               check_field("colour_class", 32'(want.colour_class),
                           32'(rsp_data.colour_class));
               check_field("glyph_index", 32'(want.glyph_index),
                           32'(rsp_data.glyph_index));
               check_field("visible", 32'(want.visible), 32'(rsp_data.visible));
               check_field("frame_end", 32'(want.frame_end), 32'(rsp_data.frame_end));
            end
         end
      end
   end

   // Response back-pressure in short random bursts.
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // The run is ended when no channel has moved a transaction for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Sends one request transaction, then idles for a random burst at times.
   task automatic push_request(input op_type op, input logic [COL_W-1:0] column);
      req_type     item;
      int unsigned gap;
      item.op          = op;
      item.seed_column = column;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits for every response and then for the block to go quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register; valid is held when another write follows at once.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data, input bit hold);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (!hold) csr_valid <= 1'b0;
   endtask

   task automatic program_frame(input logic [CSR_DATA_W-1:0] width_data,
                                input logic [CSR_DATA_W-1:0] height_data,
                                input logic [CSR_DATA_W-1:0] seed_data);
      settle_block();
      write_register(CSR_SCREEN_WIDTH, width_data, 1'b1);
      write_register(CSR_SCREEN_HEIGHT, height_data, 1'b1);
      write_register(CSR_SEED_HEAT, seed_data, 1'b0);
   endtask

   task automatic program_seed(input logic [CSR_DATA_W-1:0] seed_data);
      settle_block();
      write_register(CSR_SEED_HEAT, seed_data, 1'b0);
   endtask

   // Reset values: full frame, seed heat of 65, widest seed column.
   task automatic test_reset_values();
      push_request(OP_SEED, 7'd127);
      push_request(OP_SEED, 7'd0);
      push_request(OP_ADVANCE, 7'd0);
      push_request(OP_ADVANCE, 7'd127);
   endtask

   // Sides below two saturate to the smallest frame; the scan wraps on it.
   task automatic test_smallest_frame();
      settle_block();
      write_register(CSR_SCREEN_WIDTH, 8'd0, 1'b1);
      write_register(CSR_SCREEN_HEIGHT, 8'd1, 1'b1);
      write_register(CSR_UNUSED, 8'hFF, 1'b1);
      write_register(CSR_SEED_HEAT, 8'd127, 1'b0);
      push_request(OP_SEED, 7'd0);
      push_request(OP_SEED, 7'd127);
      repeat (3) push_request(OP_ADVANCE, COL_W'($urandom_range(0, 127)));
   endtask

   // A graded bottom row so that the top row lands in the hot, mid and dim colour classes.
   task automatic test_colour_classes();
      logic [HEAT_W-1:0] grade [6] = '{7'd40, 7'd40, 7'd24, 7'd20, 7'd4, 7'd0};
      program_frame(8'd6, 8'd2, 8'd0);
      for (int c = 0; c < 6; c++) begin
         program_seed(CSR_DATA_W'(grade[c]));
         push_request(OP_SEED, COL_W'(c));
      end
      repeat (6) push_request(OP_ADVANCE, '0);
   endtask

   // Sides above the maximum saturate to the full frame; a seed lands in its last column.
   task automatic test_register_clamps();
      program_frame(8'd255, 8'd127, 8'd0);
      push_request(OP_SEED, 7'd127);
      push_request(OP_ADVANCE, '0);
      push_request(OP_ADVANCE, '0);
   endtask

   // The frame is shrunk while the scan position still lies inside it.
   task automatic test_shrunken_scan();
      program_frame(8'd4, 8'd3, 8'd90);
      push_request(OP_SEED, 7'd2);
      repeat (4) push_request(OP_ADVANCE, '0);
      program_frame(8'd2, 8'd2, 8'd90);
      push_request(OP_ADVANCE, '0);
   endtask

   // Random phases: mostly seed bursts followed by advance runs, some noise.
   task automatic test_random_frames();
      int unsigned w, sent, seeds, advances;
      logic [CSR_DATA_W-1:0] wdata, hdata;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0: begin
               wdata = CSR_DATA_W'($urandom_range(0, 255));
               hdata = CSR_DATA_W'($urandom_range(0, 255));
            end
            1: begin
               wdata = 8'd128;
               hdata = 8'd64;
            end
            default: begin
               wdata = CSR_DATA_W'($urandom_range(2, 12));
               hdata = {1'($urandom_range(0, 1)), 7'($urandom_range(2, 8))};
            end
         endcase
         program_frame(wdata, hdata, CSR_DATA_W'($urandom_range(0, 255)));
         idling_on = (phase < RANDOM_PHASES - CALM_PHASES) ? ($urandom_range(0, 3) != 0) : 1'b0;
         w = active_columns();
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
               seeds    = $urandom_range(1, 6);
               advances = $urandom_range(4, 30);
               repeat (seeds) begin
                  if ($urandom_range(0, 3) == 0)
                     push_request(OP_SEED, COL_W'($urandom_range(0, 127)));
                  else
                     push_request(OP_SEED, COL_W'($urandom_range(0, w - 1)));
               end
               repeat (advances) push_request(OP_ADVANCE, COL_W'($urandom_range(0, 127)));
               sent += seeds + advances;
            end else begin
               repeat (8) push_request(op_type'($urandom_range(0, 1)),
                                       COL_W'($urandom_range(0, 127)));
               sent += 8;
            end
         end
      end
   endtask

   initial begin
      foreach (heat_frame[i]) heat_frame[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_smallest_frame();
      test_colour_classes();
      test_register_clamps();
      test_shrunken_scan();
      test_random_frames();
      settle_block();
      if (expected_cells.size() != 0) begin
         $error("%0d responses never arrived", expected_cells.size());
         error_count++;
      end
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/fec_pkg.sv
rtl/fec_ram.sv
rtl/fec_posdiv.sv
rtl/fec_shade.sv
rtl/fire_effect_cell_update.sv
sim/tb_fire_effect_cell_update.sv
